FILE: design/binary_heap_priority_queue_assert.svh
// assertion macros for the heap priority queue
// the including module supplies clk_i and rst_ni
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define BHPQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// expression must never be true outside reset
`define BHPQ_ASSERT_NEVER(label, expr, msg) \
  `BHPQ_ASSERT(label, !(expr), msg)

`else

`define BHPQ_ASSERT(label, prop, msg)
`define BHPQ_ASSERT_NEVER(label, expr, msg)

`endif

`endif

FILE: design/bhpq_pkg.sv
package bhpq_pkg;

  // sizing
  localparam int CAPACITY    = 64;
  localparam int DATA_W      = 32;
  localparam int CNT_W       = $clog2(CAPACITY + 1);
  localparam int NUM_LEVELS  = $clog2(CAPACITY + 1);
  localparam int LVL_W       = $clog2(NUM_LEVELS + 1);
  localparam int LAST_WORDS  = CAPACITY - (1 << (NUM_LEVELS - 1)) + 1;
  localparam int INNER_WORDS = 1 << (NUM_LEVELS - 2);
  localparam int CELL_WORDS  = (INNER_WORDS > LAST_WORDS) ? INNER_WORDS : LAST_WORDS;
  localparam int OFF_W       = (CELL_WORDS > 1) ? $clog2(CELL_WORDS) : 1;
  localparam int COUNT_OUT_W = 7;

  // request modes
  localparam logic MODE_INSERT  = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  // request and result payloads
  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] item_value;
  } bhpq_req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] top_value;
    logic [1:0]               status;
    logic [COUNT_OUT_W-1:0]   entry_count;
  } bhpq_rsp_t;

  // heap slot as level and offset within the level
  typedef struct packed {
    logic [LVL_W-1:0] lvl;
    logic [OFF_W-1:0] off;
  } bhpq_slot_t;

  // command passed down the chain of level cells
  typedef struct packed {
    logic              rd_en;
    logic [LVL_W-1:0]  rd_lvl;
    logic [OFF_W-1:0]  rd_off_a;
    logic [OFF_W-1:0]  rd_off_b;
    logic              wr_en;
    logic [LVL_W-1:0]  wr_lvl;
    logic [OFF_W-1:0]  wr_off;
    logic [DATA_W-1:0] wr_data;
  } bhpq_cmd_t;

  // read data passed back up the chain
  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } bhpq_rd_t;

  // true when a belongs strictly above b (order 0 keeps the smallest on top)
  function automatic logic ranks_above(logic signed [DATA_W-1:0] a,
                                       logic signed [DATA_W-1:0] b,
                                       logic                     order);
    return order ? (a > b) : (a < b);
  endfunction

  // map a flat heap index to its level and offset
  function automatic bhpq_slot_t slot_of(logic [CNT_W-1:0] idx);
    logic [CNT_W:0] idx1;
    bhpq_slot_t     s;
    idx1  = {1'b0, idx} + (CNT_W+1)'(1);
    s.lvl = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if (idx1 >= ((CNT_W+1)'(1) << l)) begin
        s.lvl = LVL_W'(l);
      end
    end
    s.off = OFF_W'(idx1 - ((CNT_W+1)'(1) << s.lvl));
    return s;
  endfunction

endpackage

FILE: design/bhpq_level_cell.sv
module bhpq_level_cell
  import bhpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bhpq_cmd_t cmd_i,
  output bhpq_cmd_t cmd_o,
  input  bhpq_rd_t  rd_i,
  output bhpq_rd_t  rd_o
);

  logic [DATA_W-1:0] mem_q [CELL_WORDS];
  bhpq_rd_t          data_q;
  logic              hit_q;
  logic              rd_hit;
  logic              wr_hit;

  // a command targets this level when its level field has counted down to zero
  assign rd_hit = cmd_i.rd_en && (cmd_i.rd_lvl == '0);
  assign wr_hit = cmd_i.wr_en && (cmd_i.wr_lvl == '0);

  // level storage, one write and two registered reads
  always_ff @(posedge clk_i) begin
    if (wr_hit) begin
      mem_q[cmd_i.wr_off] <= cmd_i.wr_data;
    end
    if (rd_hit) begin
      data_q.a <= mem_q[cmd_i.rd_off_a];
      data_q.b <= mem_q[cmd_i.rd_off_b];
    end
  end

  // remember which level answered the last read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= rd_hit;
    end
  end

  // hand the command to the next level down
  always_comb begin
    cmd_o        = cmd_i;
    cmd_o.rd_lvl = cmd_i.rd_lvl - LVL_W'(1);
    cmd_o.wr_lvl = cmd_i.wr_lvl - LVL_W'(1);
  end

  // read data returns toward the root
  assign rd_o = hit_q ? data_q : rd_i;

endmodule

FILE: design/binary_heap_priority_queue.sv
// channel   | ports                          | handshake
// ----------+--------------------------------+-------------------------------
// request   | start, busy, req_i             | taken when start && !busy
// result    | done_o, rsp_o                  | one-cycle strobe, no back-pressure
// config    | cfg_we_i, cfg_wdata_i          | heap order, written on cfg_we_i
//
// Insert walks up with a read state and a compare/write state per parent compared, plus a root write if it gets there.
// Extract reads root and last entry, then has a read and a compare/write state per level whose children are read.
// Each level is a cell with its own storage; a compare waits on its
// registered read, so every level step has a read state and a compare/write state.
// Extracting the only entry skips the last-entry read; a full insert or an empty extract answers straight from idle.
// The result strobe comes the cycle after the final write; reset needs no clearing pass.
`include "binary_heap_priority_queue_assert.svh"

module binary_heap_priority_queue
  import bhpq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  bhpq_req_t req_i,
  output logic      done_o,
  output bhpq_rsp_t rsp_o,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i
);

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_UP_RD   = 3'd1;
  localparam logic [2:0] ST_UP_CMP  = 3'd2;
  localparam logic [2:0] ST_EX_TOP  = 3'd3;
  localparam logic [2:0] ST_EX_LAST = 3'd4;
  localparam logic [2:0] ST_DN_RD   = 3'd5;
  localparam logic [2:0] ST_DN_CMP  = 3'd6;

  logic [2:0]        state_q, state_d;
  logic              order_q;
  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  pos_q, pos_d;
  logic [LVL_W-1:0]  lvl_q, lvl_d;
  logic [OFF_W-1:0]  off_q, off_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic              done_q, done_d;
  bhpq_rsp_t         rsp_q, rsp_d;

  bhpq_cmd_t         cmd;
  bhpq_rd_t          rd;
  bhpq_slot_t        tail_slot;
  logic [CNT_W:0]    left_idx;
  logic [CNT_W:0]    right_idx;
  logic [CNT_W:0]    count_ext;
  logic              left_ok;
  logic              right_ok;
  logic [DATA_W-1:0] best_val;
  logic [OFF_W-1:0]  child_a;
  logic [OFF_W-1:0]  child_b;

  bhpq_cmd_t cmd_chain [NUM_LEVELS+1];
  bhpq_rd_t  rd_chain  [NUM_LEVELS+1];

  // chain of level cells, root first
  assign cmd_chain[0]          = cmd;
  assign rd_chain[NUM_LEVELS]  = '0;
  assign rd                    = rd_chain[0];

  for (genvar g = 0; g < NUM_LEVELS; g++) begin : g_level
    bhpq_level_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cmd_i  (cmd_chain[g]),
      .cmd_o  (cmd_chain[g+1]),
      .rd_i   (rd_chain[g+1]),
      .rd_o   (rd_chain[g])
    );
  end

  // slot of the entry at index fill_q
  assign tail_slot = slot_of(fill_q);

  // sift-down child selection; a child moves up only past a strictly better value
  assign left_idx  = {pos_q, 1'b1};
  assign right_idx = left_idx + (CNT_W+1)'(1);
  assign count_ext = {1'b0, fill_q};
  assign child_a   = OFF_W'({off_q, 1'b0});
  assign child_b   = OFF_W'({off_q, 1'b1});
  assign left_ok   = (left_idx < count_ext) && ranks_above(rd.a, val_q, order_q);
  assign best_val  = left_ok ? rd.a : val_q;
  assign right_ok  = (right_idx < count_ext) && ranks_above(rd.b, best_val, order_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    fill_d  = fill_q;
    pos_d   = pos_q;
    lvl_d   = lvl_q;
    off_d   = off_q;
    val_d   = val_q;
    top_d   = top_q;
    done_d  = 1'b0;
    rsp_d   = rsp_q;
    cmd     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          if (req_i.mode == MODE_INSERT) begin
            if (fill_q == CNT_W'(CAPACITY)) begin
              done_d            = 1'b1;
              rsp_d.top_value   = '0;
              rsp_d.status      = STATUS_FULL;
              rsp_d.entry_count = COUNT_OUT_W'(fill_q);
            end else begin
              fill_d  = fill_q + CNT_W'(1);
              pos_d   = fill_q;
              lvl_d   = tail_slot.lvl;
              off_d   = tail_slot.off;
              val_d   = req_i.item_value;
              state_d = ST_UP_RD;
            end
          end else begin
            if (fill_q == '0) begin
              done_d            = 1'b1;
              rsp_d.top_value   = '1;
              rsp_d.status      = STATUS_EMPTY;
              rsp_d.entry_count = COUNT_OUT_W'(fill_q);
            end else begin
              fill_d     = fill_q - CNT_W'(1);
              cmd.rd_en  = 1'b1;
              state_d    = ST_EX_TOP;
            end
          end
        end
      end
      // sift up: fetch the parent
      ST_UP_RD: begin
        if (pos_q == '0) begin
          cmd.wr_en         = 1'b1;
          cmd.wr_lvl        = lvl_q;
          cmd.wr_off        = off_q;
          cmd.wr_data       = val_q;
          done_d            = 1'b1;
          rsp_d.top_value   = '0;
          rsp_d.status      = STATUS_OK;
          rsp_d.entry_count = COUNT_OUT_W'(fill_q);
          state_d           = ST_IDLE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_lvl   = lvl_q - LVL_W'(1);
          cmd.rd_off_a = off_q >> 1;
          cmd.rd_off_b = off_q >> 1;
          state_d      = ST_UP_CMP;
        end
      end
      // sift up: move the parent down or settle the new value
      ST_UP_CMP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_lvl = lvl_q;
        cmd.wr_off = off_q;
        if (ranks_above(val_q, rd.a, order_q)) begin
          cmd.wr_data = rd.a;
          pos_d       = (pos_q - CNT_W'(1)) >> 1;
          lvl_d       = lvl_q - LVL_W'(1);
          off_d       = off_q >> 1;
          state_d     = ST_UP_RD;
        end else begin
          cmd.wr_data       = val_q;
          done_d            = 1'b1;
          rsp_d.top_value   = '0;
          rsp_d.status      = STATUS_OK;
          rsp_d.entry_count = COUNT_OUT_W'(fill_q);
          state_d           = ST_IDLE;
        end
      end
      // extract: root is on the read bus, fetch the last entry
      ST_EX_TOP: begin
        top_d = rd.a;
        if (fill_q == '0) begin
          done_d            = 1'b1;
          rsp_d.top_value   = rd.a;
          rsp_d.status      = STATUS_OK;
          rsp_d.entry_count = COUNT_OUT_W'(fill_q);
          state_d           = ST_IDLE;
        end else begin
          cmd.rd_en    = 1'b1;
          cmd.rd_lvl   = tail_slot.lvl;
          cmd.rd_off_a = tail_slot.off;
          cmd.rd_off_b = tail_slot.off;
          state_d      = ST_EX_LAST;
        end
      end
      // extract: last entry becomes the value sifted down from the root
      ST_EX_LAST: begin
        val_d   = rd.a;
        pos_d   = '0;
        lvl_d   = '0;
        off_d   = '0;
        state_d = ST_DN_RD;
      end
      // sift down: fetch both children
      ST_DN_RD: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_lvl   = lvl_q + LVL_W'(1);
        cmd.rd_off_a = child_a;
        cmd.rd_off_b = child_b;
        state_d      = ST_DN_CMP;
      end
      // sift down: promote the better child or settle the value
      ST_DN_CMP: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_lvl = lvl_q;
        cmd.wr_off = off_q;
        if (right_ok) begin
          cmd.wr_data = rd.b;
          pos_d       = CNT_W'(right_idx);
          lvl_d       = lvl_q + LVL_W'(1);
          off_d       = child_b;
          state_d     = ST_DN_RD;
        end else if (left_ok) begin
          cmd.wr_data = rd.a;
          pos_d       = CNT_W'(left_idx);
          lvl_d       = lvl_q + LVL_W'(1);
          off_d       = child_a;
          state_d     = ST_DN_RD;
        end else begin
          cmd.wr_data       = val_q;
          done_d            = 1'b1;
          rsp_d.top_value   = top_q;
          rsp_d.status      = STATUS_OK;
          rsp_d.entry_count = COUNT_OUT_W'(fill_q);
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      fill_q  <= '0;
      order_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        order_q <= cfg_wdata_i;
      end
    end
  end

  // working registers and result payload
  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
    lvl_q <= lvl_d;
    off_q <= off_d;
    val_q <= val_d;
    top_q <= top_d;
    rsp_q <= rsp_d;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // checks
  `BHPQ_ASSERT(a_fill_bound, fill_q <= CNT_W'(CAPACITY), "fill level beyond capacity")
  `BHPQ_ASSERT(a_start_answered, (start && !busy) |=> (busy || done_o),
               "accepted request neither started nor answered")
  `BHPQ_ASSERT(a_full_count,
               (done_o && rsp_o.status == STATUS_FULL) |-> (fill_q == CNT_W'(CAPACITY)),
               "full status while heap not full")
  `BHPQ_ASSERT_NEVER(a_done_idle, done_o && busy, "result strobe while still busy")
  `BHPQ_ASSERT(a_down_level, (state_q == ST_DN_CMP) |-> (lvl_q < LVL_W'(NUM_LEVELS)),
               "sift down beyond the deepest level")

endmodule
